### rtl/bstri_pkg.sv
`default_nettype none
package bstri_pkg;

  localparam int DOCS        = 64;
  localparam int TS_BITS     = 64;
  localparam int TS_W        = 64;
  localparam int MAP_W       = 64;
  localparam int KEY_W       = 6;
  localparam int OP_W        = 2;
  localparam int POS_W       = 6;
  localparam int STORE_WORDS = 256;
  localparam int ADDR_W      = 8;

  localparam logic [MAP_W-1:0] DOC_MASK =
    (DOCS >= MAP_W) ? {MAP_W{1'b1}} : MAP_W'((65'd1 << DOCS) - 65'd1);

  localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY_GE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY_LE = 2'd2;

  typedef enum logic [1:0] {
    VAL_ZERO,
    VAL_ONE,
    VAL_TS,
    VAL_WANT
  } addr_val_e;

  typedef struct packed {
    logic             load;
    addr_val_e        val_sel;
    logic [POS_W-1:0] pos;
    logic             wr_en;
    logic             pf_init;
    logic             pf_or;
    logic             step;
    logic             out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  function automatic logic [ADDR_W-1:0] slot_addr(logic kind, logic [POS_W-1:0] pos,
                                                  logic val);
    int word;
    word = ((int'(kind) * TS_BITS) + int'(pos)) * 2 + int'(val);
    return ADDR_W'(word);
  endfunction

endpackage
`default_nettype wire

### rtl/bstri_in_if.sv
`default_nettype none
interface bstri_in_if;
  logic                          valid;
  logic                          ready;
  logic [bstri_pkg::OP_W-1:0]    operation;
  logic [bstri_pkg::KEY_W-1:0]   doc_key;
  logic [bstri_pkg::TS_W-1:0]    timestamp;
  logic                          kind;

  modport source (output valid, output operation, output doc_key, output timestamp,
                  output kind, input ready);
  modport sink (input valid, input operation, input doc_key, input timestamp,
                input kind, output ready);
endinterface
`default_nettype wire

### rtl/bstri_out_if.sv
`default_nettype none
interface bstri_out_if;
  logic                        valid;
  logic                        ready;
  logic [bstri_pkg::MAP_W-1:0] match_map;

  modport source (output valid, output match_map, input ready);
  modport sink (input valid, input match_map, output ready);
endinterface
`default_nettype wire

### rtl/bstri_dp.sv
`default_nettype none
module bstri_dp (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire bstri_pkg::ctrl_cmd_t          cmd_i,
  input  wire logic [bstri_pkg::OP_W-1:0]    op_i,
  input  wire logic [bstri_pkg::KEY_W-1:0]   key_i,
  input  wire logic [bstri_pkg::TS_W-1:0]    ts_i,
  input  wire logic                          kind_i,
  input  wire logic                          out_ready_i,
  output bstri_pkg::dp_stat_t                stat_o,
  output logic                               out_valid_o,
  output logic [bstri_pkg::MAP_W-1:0]        match_map_o
);

  logic [bstri_pkg::MAP_W-1:0]       mem [bstri_pkg::STORE_WORDS];
  logic [bstri_pkg::STORE_WORDS-1:0] vld_q;
  logic [bstri_pkg::MAP_W-1:0]       rdata_q;
  logic                              rvld_q;
  logic [bstri_pkg::POS_W-1:0]       rpos_q;

  logic [bstri_pkg::TS_W-1:0]  ts_q;
  logic [bstri_pkg::KEY_W-1:0] key_q;
  logic                        kind_q;
  logic                        want_q;

  logic [bstri_pkg::MAP_W-1:0] prefix_q, prefix_d;
  logic [bstri_pkg::MAP_W-1:0] result_q, result_d;
  logic [bstri_pkg::MAP_W-1:0] out_data_q;
  logic                        out_valid_q;

  logic                         val;
  logic [bstri_pkg::ADDR_W-1:0] addr;
  logic [bstri_pkg::MAP_W-1:0]  rd_eff;
  logic [bstri_pkg::MAP_W-1:0]  doc_bit;
  logic                         key_ok;

  always_comb begin
    case (cmd_i.val_sel)
      bstri_pkg::VAL_ZERO: val = 1'b0;
      bstri_pkg::VAL_ONE:  val = 1'b1;
      bstri_pkg::VAL_TS:   val = ts_q[cmd_i.pos];
      bstri_pkg::VAL_WANT: val = want_q;
      default:             val = 1'b0;
    endcase
  end

  assign addr    = bstri_pkg::slot_addr(kind_q, cmd_i.pos, val);
  assign rd_eff  = rvld_q ? rdata_q : '0;
  assign key_ok  = ({1'b0, key_q} < (bstri_pkg::KEY_W + 1)'(bstri_pkg::DOCS));
  assign doc_bit = key_ok ? (bstri_pkg::MAP_W'(1) << key_q) : '0;

  // slice memory, one access port, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem[addr] <= rd_eff | doc_bit;
    end
    rdata_q <= mem[addr];
    rpos_q  <= cmd_i.pos;
  end

  // per-word written flags, unwritten words read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (cmd_i.wr_en) begin
        vld_q[addr] <= 1'b1;
      end
      rvld_q <= vld_q[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ts_q   <= ts_i;
      key_q  <= key_i;
      kind_q <= kind_i;
      want_q <= (op_i == bstri_pkg::OP_QUERY_GE);
    end
    prefix_q <= prefix_d;
    result_q <= result_d;
  end

  always_comb begin
    prefix_d = prefix_q;
    result_d = result_q;
    if (cmd_i.pf_init) begin
      prefix_d = rd_eff;
    end
    if (cmd_i.pf_or) begin
      prefix_d = prefix_q | rd_eff;
      result_d = '0;
    end
    if (cmd_i.step) begin
      if (ts_q[rpos_q] != want_q) begin
        result_d = result_q | (prefix_q & rd_eff);
      end else begin
        prefix_d = prefix_q & rd_eff;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= (result_q | prefix_q) & bstri_pkg::DOC_MASK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign match_map_o     = out_data_q;

endmodule
`default_nettype wire

### rtl/bstri_ctrl.sv
`default_nettype none
module bstri_ctrl (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic [bstri_pkg::OP_W-1:0] op_i,
  input  wire bstri_pkg::dp_stat_t        stat_i,
  output logic                            in_ready_o,
  output bstri_pkg::ctrl_cmd_t            cmd_o
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_INS_RD = 3'd1;
  localparam logic [2:0] ST_INS_WR = 3'd2;
  localparam logic [2:0] ST_Q_P0   = 3'd3;
  localparam logic [2:0] ST_Q_P1   = 3'd4;
  localparam logic [2:0] ST_Q_WALK = 3'd5;
  localparam logic [2:0] ST_Q_LAST = 3'd6;
  localparam logic [2:0] ST_Q_DONE = 3'd7;

  localparam logic [bstri_pkg::POS_W-1:0] POS_TOP = bstri_pkg::POS_W'(bstri_pkg::TS_BITS - 1);

  logic [2:0]                  state_q, state_d;
  logic [bstri_pkg::POS_W-1:0] pos_q, pos_d;
  logic                        accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d        = state_q;
    pos_d          = pos_q;
    cmd_o          = '0;
    cmd_o.val_sel  = bstri_pkg::VAL_ZERO;
    cmd_o.pos      = pos_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = accept;
        if (accept) begin
          unique case (op_i) inside
            bstri_pkg::OP_INSERT: begin
              pos_d   = '0;
              state_d = ST_INS_RD;
            end
            bstri_pkg::OP_QUERY_GE, bstri_pkg::OP_QUERY_LE: begin
              state_d = ST_Q_P0;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_INS_RD: begin
        cmd_o.val_sel = bstri_pkg::VAL_TS;
        state_d       = ST_INS_WR;
      end
      ST_INS_WR: begin
        cmd_o.val_sel = bstri_pkg::VAL_TS;
        cmd_o.wr_en   = 1'b1;
        if (pos_q == POS_TOP) begin
          state_d = ST_IDLE;
        end else begin
          pos_d   = pos_q + 1'b1;
          state_d = ST_INS_RD;
        end
      end
      ST_Q_P0: begin
        cmd_o.pos = '0;
        state_d   = ST_Q_P1;
      end
      ST_Q_P1: begin
        cmd_o.pos     = '0;
        cmd_o.val_sel = bstri_pkg::VAL_ONE;
        cmd_o.pf_init = 1'b1;
        pos_d         = POS_TOP;
        state_d       = ST_Q_WALK;
      end
      ST_Q_WALK: begin
        cmd_o.val_sel = bstri_pkg::VAL_WANT;
        // first walk cycle still folds in the second position-zero slice
        if (pos_q == POS_TOP) begin
          cmd_o.pf_or = 1'b1;
        end else begin
          cmd_o.step = 1'b1;
        end
        if (pos_q == '0) begin
          state_d = ST_Q_LAST;
        end else begin
          pos_d = pos_q - 1'b1;
        end
      end
      ST_Q_LAST: begin
        cmd_o.step = 1'b1;
        state_d    = ST_Q_DONE;
      end
      ST_Q_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pos_q   <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
    end
  end

`ifndef SYNTHESIS
  a_wr_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_en |-> $past(state_q) == ST_INS_RD)
    else $error("slice write without preceding read");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> stat_i.out_free)
    else $error("result loaded over a pending item");

  a_insert_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op_i == bstri_pkg::OP_INSERT) |=> (state_q == ST_INS_RD && pos_q == '0))
    else $error("insert did not start at position zero");

  a_walk_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_Q_LAST) |-> ($past(state_q) == ST_Q_WALK && $past(pos_q) == '0))
    else $error("walk ended early");
`endif

endmodule
`default_nettype wire

### rtl/bit_sliced_timestamp_range_index_unit.sv
`default_nettype none
// bit-sliced range index over 64-bit begin and end timestamps, 64 documents
// in_i: one item per handshake, operation insert, query >= or query <=,
//   with doc_key, timestamp and kind (0 begin, 1 end)
// out_o carries nothing for an insert; each query gives one item on out_o,
//   match_map with bit i set for every matching document
// insert: 64 read-modify-write passes on the single-port slice memory,
//   each a read then a write; the next item is taken after the last write
// query: two reads of the position-zero slices, then one slice read per
//   position; the result is registered once the output register is free,
//   and the next item can be taken in the following cycle
// unknown operation: taken and dropped, next item in the following cycle
// throughput is set by the one memory port: one slice word per cycle when busy
// reset: slice store reads as all zero (per-word written flags are
//   cleared), controller idle, no result pending; no clearing pass
// a stalled result stays in the output register; the next item is taken
//   meanwhile, and a query waits at its end until the register is free
module bit_sliced_timestamp_range_index_unit (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  bstri_in_if.sink    in_i,
  bstri_out_if.source out_o
);

  bstri_pkg::ctrl_cmd_t cmd;
  bstri_pkg::dp_stat_t  stat;
  logic                 in_ready;
  logic                 out_valid;
  logic [bstri_pkg::MAP_W-1:0] match_map;

  bstri_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .op_i       (in_i.operation),
    .stat_i     (stat),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  bstri_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .op_i        (in_i.operation),
    .key_i       (in_i.doc_key),
    .ts_i        (in_i.timestamp),
    .kind_i      (in_i.kind),
    .out_ready_i (out_o.ready),
    .stat_o      (stat),
    .out_valid_o (out_valid),
    .match_map_o (match_map)
  );

  assign in_i.ready      = in_ready;
  assign out_o.valid     = out_valid;
  assign out_o.match_map = match_map;

endmodule
`default_nettype wire

### tb/tb_bit_sliced_timestamp_range_index_unit.sv
`default_nettype none
module tb_bit_sliced_timestamp_range_index_unit;
  import bstri_pkg::*;

  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;
  localparam int RANDOM_ITEMS = 1500;
  localparam int TAIL_ITEMS   = 150;
  localparam int DRAIN_CYCLES = 200;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PRINT_LIMIT  = 50;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
    logic [TS_W-1:0]  ts;
    logic             kind;
  } index_req_t;

  logic clk_i;
  logic rst_ni;

  bstri_in_if  in_ch ();
  bstri_out_if out_ch ();

  bit_sliced_timestamp_range_index_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  logic [MAP_W-1:0] slice_bank [2][TS_BITS][2];
  logic [MAP_W-1:0] expected_maps [$];
  index_req_t       pending_reqs [$];
  logic [TS_W-1:0]  inserted_ts [$];
  logic [TS_W-1:0]  ts_bases [4];
  index_req_t       next_req;
  logic [MAP_W-1:0] want_map;
  logic             in_taken;
  logic             calm_tail;
  int               in_gap;
  int               out_gap;
  int               accepted_count;
  int               total_reqs;
  int               fail_count;
  int               cycle_count;

  assign calm_tail = (accepted_count + TAIL_ITEMS >= total_reqs);

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic logic [MAP_W-1:0] predict_match(logic [TS_W-1:0] ts, logic kind,
                                                     logic want);
    logic [MAP_W-1:0] prefix;
    logic [MAP_W-1:0] hits;
    logic [MAP_W-1:0] slice;
    int p;
    prefix = slice_bank[kind][0][0] | slice_bank[kind][0][1];
    hits = '0;
    for (p = TS_BITS - 1; p >= 0; p--) begin
      slice = slice_bank[kind][p][want];
      if (ts[p] != want) begin
        hits = hits | (prefix & slice);
      end else begin
        prefix = prefix & slice;
      end
    end
    return (hits | prefix) & DOC_MASK;
  endfunction

  task automatic record_insert(logic [KEY_W-1:0] key, logic [TS_W-1:0] ts, logic kind);
    int p;
    if (int'(key) < DOCS) begin
      for (p = 0; p < TS_BITS; p++) begin
        slice_bank[kind][p][ts[p]] = slice_bank[kind][p][ts[p]] | (MAP_W'(1) << key);
      end
    end
  endtask

  task automatic report_mismatch(string what, logic [MAP_W-1:0] got, logic [MAP_W-1:0] want);
    if (fail_count < PRINT_LIMIT) begin
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    end
    fail_count++;
  endtask

  task automatic add_req(logic [OP_W-1:0] op, logic [KEY_W-1:0] key, logic [TS_W-1:0] ts,
                         logic kind);
    index_req_t r;
    r.op = op;
    r.key = key;
    r.ts = ts;
    r.kind = kind;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [TS_W-1:0] rand_ts();
    logic [TS_W-1:0] base;
    base = ts_bases[$urandom_range(0, 3)];
    case ($urandom_range(0, 5))
      0: return {$urandom(), $urandom()};
      1: return base ^ (TS_W'(1) << $urandom_range(0, TS_W - 1));
      2: return {base[TS_W-1:4], 4'($urandom())};
      default: return {base[TS_W-1:12], 12'($urandom())};
    endcase
  endfunction

  function automatic logic [TS_W-1:0] near_ts();
    logic [TS_W-1:0] t;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return rand_ts();
      default: begin
        if (inserted_ts.size() == 0) begin
          return rand_ts();
        end
        t = inserted_ts[$urandom_range(0, inserted_ts.size() - 1)];
        return t + TS_W'($urandom_range(0, 4)) - TS_W'(2);
      end
    endcase
  endfunction

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_ch.valid || in_taken) begin
        if (in_gap != 0) begin
          in_ch.valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (!calm_tail && $urandom_range(0, 3) == 0) begin
          in_ch.valid <= 1'b0;
          in_gap <= $urandom_range(0, 15);
        end else if (pending_reqs.size() != 0) begin
          next_req = pending_reqs.pop_front();
          in_ch.operation <= next_req.op;
          in_ch.doc_key <= next_req.key;
          in_ch.timestamp <= next_req.ts;
          in_ch.kind <= next_req.kind;
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      if (out_gap != 0) begin
        out_ch.ready <= 1'b0;
        out_gap <= out_gap - 1;
      end else if (!calm_tail && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        out_gap <= $urandom_range(0, 15);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // monitor and predictor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_maps.size() == 0) begin
          report_mismatch("unexpected match_map", out_ch.match_map, '0);
        end else begin
          want_map = expected_maps.pop_front();
          if (out_ch.match_map !== want_map) begin
            report_mismatch("match_map", out_ch.match_map, want_map);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        accepted_count++;
        case (in_ch.operation)
          OP_INSERT: record_insert(in_ch.doc_key, in_ch.timestamp, in_ch.kind);
          OP_QUERY_GE: expected_maps.push_back(predict_match(in_ch.timestamp, in_ch.kind, 1'b1));
          OP_QUERY_LE: expected_maps.push_back(predict_match(in_ch.timestamp, in_ch.kind, 1'b0));
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int n;
    int r;
    logic [TS_W-1:0] t;
    logic k;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_INSERT;
    in_ch.doc_key = '0;
    in_ch.timestamp = '0;
    in_ch.kind = 1'b0;
    out_ch.ready = 1'b0;
    in_taken = 1'b0;
    in_gap = 0;
    out_gap = 0;
    accepted_count = 0;
    fail_count = 0;
    cycle_count = 0;
    total_reqs = 1 << 30;
    foreach (slice_bank[a, b, c]) slice_bank[a][b][c] = '0;
    foreach (ts_bases[i]) ts_bases[i] = {$urandom(), $urandom()};

    // empty store, extremes, accumulation, ignored operation
    add_req(OP_QUERY_GE, '0, '0, 1'b0);
    add_req(OP_QUERY_LE, '1, '1, 1'b1);
    add_req(OP_UNKNOWN, '1, '1, 1'b1);
    add_req(OP_INSERT, 6'd0, '0, 1'b0);
    add_req(OP_INSERT, 6'd63, '1, 1'b0);
    add_req(OP_INSERT, 6'd21, 64'h5555_5555_5555_5555, 1'b1);
    add_req(OP_INSERT, 6'd42, 64'haaaa_aaaa_aaaa_aaaa, 1'b1);
    add_req(OP_QUERY_GE, '0, '0, 1'b0);
    add_req(OP_QUERY_LE, '0, '0, 1'b0);
    add_req(OP_QUERY_GE, '0, '1, 1'b0);
    add_req(OP_QUERY_LE, '0, '1, 1'b0);
    add_req(OP_QUERY_GE, '0, 64'h5555_5555_5555_5555, 1'b1);
    add_req(OP_QUERY_LE, '0, 64'h5555_5555_5555_5555, 1'b1);
    add_req(OP_QUERY_GE, '1, 64'haaaa_aaaa_aaaa_aaaa, 1'b1);
    add_req(OP_QUERY_LE, '1, 64'haaaa_aaaa_aaaa_aaab, 1'b1);
    add_req(OP_QUERY_GE, '0, '0, 1'b1);
    add_req(OP_INSERT, 6'd0, 64'h8000_0000_0000_0000, 1'b0);
    add_req(OP_QUERY_GE, '0, 64'h8000_0000_0000_0000, 1'b0);
    add_req(OP_QUERY_LE, '0, 64'h7fff_ffff_ffff_ffff, 1'b0);
    add_req(OP_UNKNOWN, '0, '0, 1'b0);
    add_req(OP_QUERY_LE, '0, '0, 1'b1);
    inserted_ts.push_back(64'h5555_5555_5555_5555);
    inserted_ts.push_back(64'haaaa_aaaa_aaaa_aaaa);

    n = 0;
    while (n < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      k = 1'(($urandom()));
      if (r < 35) begin
        t = rand_ts();
        inserted_ts.push_back(t);
        add_req(OP_INSERT, KEY_W'($urandom()), t, k);
        n++;
      end else if (r < 97) begin
        add_req((r & 1) ? OP_QUERY_GE : OP_QUERY_LE, KEY_W'($urandom()), near_ts(), k);
        n++;
      end else begin
        add_req(OP_UNKNOWN, KEY_W'($urandom()), {$urandom(), $urandom()}, k);
      end
    end
    total_reqs = pending_reqs.size();

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_count < total_reqs) @(negedge clk_i);
    while (expected_maps.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

### bit_sliced_timestamp_range_index_unit.f
rtl/bstri_pkg.sv
rtl/bstri_in_if.sv
rtl/bstri_out_if.sv
rtl/bstri_dp.sv
rtl/bstri_ctrl.sv
rtl/bit_sliced_timestamp_range_index_unit.sv
tb/tb_bit_sliced_timestamp_range_index_unit.sv
